[rtl/core/binary_to_decimal_ascii_core_defines.svh]
// ---------------------------------------------------------------------------
// Binary to decimal ASCII core: assertion macros
// Shared property shorthands for the checker of the conversion core.
// ---------------------------------------------------------------------------
`ifndef BINARY_TO_DECIMAL_ASCII_CORE_DEFINES_SVH
`define BINARY_TO_DECIMAL_ASCII_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high
`define B2DA_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high
`define B2DA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/core/b2da_pkg.sv]
// ---------------------------------------------------------------------------
// Binary to decimal ASCII package
// Widths, character codes, defaults and shared types of the conversion core.
// ---------------------------------------------------------------------------
package b2da_pkg;

   // Port widths fixed by the item format
   localparam int INPUT_W  = 64;
   localparam int CHAR_W   = 8;
   localparam int COUNT_W  = 5;
   localparam int DIGIT_W  = 4;
   localparam int MAX_CHARS = 20;

   // Defaults for the top-level parameters
   localparam int VALUE_WIDTH_DEFAULT = 64;
   localparam int QUEUE_DEPTH_DEFAULT = 2;

   // Reset value of the signed mode register
   localparam logic SIGNED_MODE_RESET = 1'b1;

   // Character codes
   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

   // Queue status seen by the front and the back
   typedef struct packed {
      logic full;
      logic not_empty;
   } queue_status_type;

   // Decimal digits needed for a value of the given bit width
   function automatic int decimal_digits(input int width);
      return ((width * 1233) >> 12) + 1;
   endfunction

endpackage

[rtl/core/b2da_front.sv]
// ---------------------------------------------------------------------------
// Binary to decimal ASCII front
// Holds the signed mode register, accepts input items and splits each one
// into sign and magnitude before it enters the queue.
// ---------------------------------------------------------------------------
module b2da_front #(
   parameter int VALUE_WIDTH = b2da_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   // configuration
   input  logic                            csr_wr_en,
   input  logic                            csr_wr_data,
   // request channel
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [b2da_pkg::INPUT_W-1:0]    req_value,
   // queue side
   input  b2da_pkg::queue_status_type      queue_status,
   output logic                            push,
   output logic [VALUE_WIDTH-1:0]          push_mag,
   output logic                            push_neg
);
   import b2da_pkg::*;

   logic                   signed_mode_ff;
   logic                   signed_mode_in;
   logic [VALUE_WIDTH-1:0] raw;

   // Update the mode register on a write
   always_comb begin
      signed_mode_in = signed_mode_ff;
      if (csr_wr_en) begin
         signed_mode_in = csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         signed_mode_ff <= SIGNED_MODE_RESET;
      end else begin
         signed_mode_ff <= signed_mode_in;
      end
   end

   // Classify: drop the bits above the width, take the magnitude of negatives
   assign raw      = req_value[VALUE_WIDTH-1:0];
   assign push_neg = signed_mode_ff & raw[VALUE_WIDTH-1];
   assign push_mag = push_neg ? (~raw + VALUE_WIDTH'(1)) : raw;

   // Take a transfer whenever the queue has room
   assign req_stall = queue_status.full;
   assign push      = req_valid & ~queue_status.full;

endmodule

[rtl/core/b2da_queue.sv]
// ---------------------------------------------------------------------------
// Binary to decimal ASCII queue
// Short register queue of classified items between the front and the back.
// ---------------------------------------------------------------------------
module b2da_queue #(
   parameter int VALUE_WIDTH = b2da_pkg::VALUE_WIDTH_DEFAULT,
   parameter int QUEUE_DEPTH = b2da_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic [VALUE_WIDTH-1:0]     push_mag,
   input  logic                       push_neg,
   input  logic                       pop,
   output logic [VALUE_WIDTH-1:0]     pop_mag,
   output logic                       pop_neg,
   output b2da_pkg::queue_status_type queue_status
);
   import b2da_pkg::*;

   localparam int PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int COUNT_QW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0]    LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [COUNT_QW-1:0] FULL_CNT = COUNT_QW'(QUEUE_DEPTH);

   logic [VALUE_WIDTH-1:0] mag_ff [QUEUE_DEPTH];
   logic                   neg_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]       wr_ptr_ff;
   logic [PTR_W-1:0]       wr_ptr_in;
   logic [PTR_W-1:0]       rd_ptr_ff;
   logic [PTR_W-1:0]       rd_ptr_in;
   logic [COUNT_QW-1:0]    count_ff;
   logic [COUNT_QW-1:0]    count_in;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + COUNT_QW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - COUNT_QW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store entries
   always_ff @(posedge clock) begin
      if (push) begin
         mag_ff[wr_ptr_ff] <= push_mag;
         neg_ff[wr_ptr_ff] <= push_neg;
      end
   end

   assign pop_mag                = mag_ff[rd_ptr_ff];
   assign pop_neg                = neg_ff[rd_ptr_ff];
   assign queue_status.full      = (count_ff == FULL_CNT);
   assign queue_status.not_empty = (count_ff != '0);

endmodule

[rtl/core/b2da_back.sv]
// ---------------------------------------------------------------------------
// Binary to decimal ASCII back
// Converts a magnitude to BCD by shift-add-3, four bits a cycle, then emits
// the sign and the digits one character per transfer through an output
// register. The next conversion runs while the current text is emitted.
// ---------------------------------------------------------------------------
module b2da_back #(
   parameter int VALUE_WIDTH = b2da_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   // queue side
   input  b2da_pkg::queue_status_type      queue_status,
   input  logic [VALUE_WIDTH-1:0]          pop_mag,
   input  logic                            pop_neg,
   output logic                            pop,
   // response channel
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [b2da_pkg::CHAR_W-1:0]     rsp_text_char,
   output logic [b2da_pkg::COUNT_W-1:0]    rsp_char_count,
   output logic                            rsp_last
);
   import b2da_pkg::*;

   localparam int PAD_W      = ((VALUE_WIDTH + 3) / 4) * 4;
   localparam int NUM_STEPS  = PAD_W / 4;
   localparam int STEP_W     = (NUM_STEPS > 1) ? $clog2(NUM_STEPS) : 1;
   localparam int NUM_DIGITS = decimal_digits(VALUE_WIDTH);
   localparam int BCD_W      = NUM_DIGITS * DIGIT_W;
   localparam int IDX_W      = $clog2(NUM_DIGITS);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NUM_STEPS - 1);

   typedef enum logic [2:0] {
      CONV_IDLE = 3'b001,
      CONV_RUN  = 3'b010,
      CONV_HOLD = 3'b100
   } conv_state_type;

   typedef enum logic [2:0] {
      EMIT_IDLE   = 3'b001,
      EMIT_SIGN   = 3'b010,
      EMIT_DIGITS = 3'b100
   } emit_state_type;

   // converter
   conv_state_type      conv_state_ff;
   conv_state_type      conv_state_in;
   logic [PAD_W-1:0]    bin_ff;
   logic [PAD_W-1:0]    bin_in;
   logic [BCD_W-1:0]    bcd_ff;
   logic [BCD_W-1:0]    bcd_in;
   logic                conv_neg_ff;
   logic                conv_neg_in;
   logic [STEP_W-1:0]   step_ff;
   logic [STEP_W-1:0]   step_in;
   logic [PAD_W-1:0]    bin_step;
   logic [BCD_W-1:0]    bcd_step;
   logic [COUNT_W-1:0]  num_sig;
   logic [COUNT_W-1:0]  num_sig_m1;
   logic                handoff;

   // emitter
   emit_state_type      em_state_ff;
   emit_state_type      em_state_in;
   logic [DIGIT_W-1:0]  em_digit_ff [NUM_DIGITS];
   logic [IDX_W-1:0]    em_idx_ff;
   logic [IDX_W-1:0]    em_idx_in;
   logic [COUNT_W-1:0]  em_total_ff;
   logic [COUNT_W-1:0]  em_total_in;
   logic [DIGIT_W-1:0]  cur_digit;
   logic                out_free;

   // output register
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic [CHAR_W-1:0]   rsp_char_ff;
   logic [CHAR_W-1:0]   rsp_char_in;
   logic [COUNT_W-1:0]  rsp_count_ff;
   logic [COUNT_W-1:0]  rsp_count_in;
   logic                rsp_last_ff;
   logic                rsp_last_in;

   // Four shift-add-3 steps per cycle
   always_comb begin
      bcd_step = bcd_ff;
      bin_step = bin_ff;
      for (int s = 0; s < 4; s++) begin
         for (int d = 0; d < NUM_DIGITS; d++) begin
            if (bcd_step[d*DIGIT_W +: DIGIT_W] >= DIGIT_W'(5)) begin
               bcd_step[d*DIGIT_W +: DIGIT_W] =
                  bcd_step[d*DIGIT_W +: DIGIT_W] + DIGIT_W'(3);
            end
         end
         bcd_step = {bcd_step[BCD_W-2:0], bin_step[PAD_W-1]};
         bin_step = {bin_step[PAD_W-2:0], 1'b0};
      end
   end

   // Hand the finished BCD word over once the emitter is free
   assign handoff = (conv_state_ff == CONV_HOLD) && (em_state_ff == EMIT_IDLE);
   assign pop     = (conv_state_ff == CONV_IDLE) && queue_status.not_empty;

   // Converter sequencing
   always_comb begin
      conv_state_in = conv_state_ff;
      bin_in        = bin_ff;
      bcd_in        = bcd_ff;
      conv_neg_in   = conv_neg_ff;
      step_in       = step_ff;
      case (conv_state_ff)
         CONV_IDLE: begin
            if (queue_status.not_empty) begin
               bin_in        = PAD_W'(pop_mag);
               bcd_in        = '0;
               conv_neg_in   = pop_neg;
               step_in       = '0;
               conv_state_in = CONV_RUN;
            end
         end
         CONV_RUN: begin
            bin_in  = bin_step;
            bcd_in  = bcd_step;
            step_in = step_ff + STEP_W'(1);
            if (step_ff == LAST_STEP) begin
               conv_state_in = CONV_HOLD;
            end
         end
         CONV_HOLD: begin
            if (handoff) begin
               conv_state_in = CONV_IDLE;
            end
         end
         default: begin
            conv_state_in = CONV_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         conv_state_ff <= CONV_IDLE;
         step_ff       <= '0;
      end else begin
         conv_state_ff <= conv_state_in;
         step_ff       <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      bin_ff      <= bin_in;
      bcd_ff      <= bcd_in;
      conv_neg_ff <= conv_neg_in;
   end

   // Count significant digits; zero still shows one digit
   always_comb begin
      num_sig = COUNT_W'(1);
      for (int d = 1; d < NUM_DIGITS; d++) begin
         if (bcd_ff[d*DIGIT_W +: DIGIT_W] != '0) begin
            num_sig = COUNT_W'(d + 1);
         end
      end
   end

   assign num_sig_m1 = num_sig - COUNT_W'(1);
   assign cur_digit  = em_digit_ff[em_idx_ff];
   assign out_free   = ~rsp_valid_ff | ~rsp_stall;

   // Emitter sequencing and output register load
   always_comb begin
      em_state_in  = em_state_ff;
      em_idx_in    = em_idx_ff;
      em_total_in  = em_total_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_count_in = rsp_count_ff;
      rsp_last_in  = rsp_last_ff;
      if (out_free) begin
         rsp_valid_in = 1'b0;
      end
      case (em_state_ff)
         EMIT_IDLE: begin
            if (handoff) begin
               em_idx_in   = num_sig_m1[IDX_W-1:0];
               em_total_in = num_sig + COUNT_W'(conv_neg_ff);
               em_state_in = conv_neg_ff ? EMIT_SIGN : EMIT_DIGITS;
            end
         end
         EMIT_SIGN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = CHAR_MINUS;
               rsp_count_in = '0;
               rsp_last_in  = 1'b0;
               em_state_in  = EMIT_DIGITS;
            end
         end
         EMIT_DIGITS: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = CHAR_ZERO + CHAR_W'(cur_digit);
               if (em_idx_ff == '0) begin
                  rsp_count_in = em_total_ff;
                  rsp_last_in  = 1'b1;
                  em_state_in  = EMIT_IDLE;
               end else begin
                  rsp_count_in = '0;
                  rsp_last_in  = 1'b0;
                  em_idx_in    = em_idx_ff - IDX_W'(1);
               end
            end
         end
         default: begin
            em_state_in = EMIT_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         em_state_ff  <= EMIT_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         em_state_ff  <= em_state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      em_idx_ff    <= em_idx_in;
      em_total_ff  <= em_total_in;
      rsp_char_ff  <= rsp_char_in;
      rsp_count_ff <= rsp_count_in;
      rsp_last_ff  <= rsp_last_in;
      if (handoff) begin
         for (int d = 0; d < NUM_DIGITS; d++) begin
            em_digit_ff[d] <= bcd_ff[d*DIGIT_W +: DIGIT_W];
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_text_char  = rsp_char_ff;
   assign rsp_char_count = rsp_count_ff;
   assign rsp_last       = rsp_last_ff;

endmodule

[rtl/core/binary_to_decimal_ascii_core.sv]
// ---------------------------------------------------------------------------
// Binary to decimal ASCII core
// Converts one integer per request into its decimal text, one character per
// response transfer, most significant character first.
// ---------------------------------------------------------------------------
// The low VALUE_WIDTH bits of req_value are read as two's complement when
// csr_wr_data last written was 1 (the reset value) and as unsigned when 0;
// write the register only while the core is idle. A negative number gives a
// leading '-' and then the digits of its magnitude, zero gives "0", and the
// final character carries rsp_last with the text length in rsp_char_count
// (zero on every other character). Requests enter a QUEUE_DEPTH-entry queue,
// and req_stall is raised while the queue is full. The converter runs four
// shift-add-3 steps a cycle and works on the next number while the emitter
// sends the current text at one character per cycle when rsp_stall allows.
// ---------------------------------------------------------------------------
module binary_to_decimal_ascii_core #(
   parameter int VALUE_WIDTH = b2da_pkg::VALUE_WIDTH_DEFAULT,
   parameter int QUEUE_DEPTH = b2da_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   // configuration
   input  logic                            csr_wr_en,
   input  logic                            csr_wr_data,
   // request channel
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [b2da_pkg::INPUT_W-1:0]    req_value,
   // response channel
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [b2da_pkg::CHAR_W-1:0]     rsp_text_char,
   output logic [b2da_pkg::COUNT_W-1:0]    rsp_char_count,
   output logic                            rsp_last
);
   import b2da_pkg::*;

   queue_status_type       queue_status;
   logic                   push;
   logic [VALUE_WIDTH-1:0] push_mag;
   logic                   push_neg;
   logic                   pop;
   logic [VALUE_WIDTH-1:0] pop_mag;
   logic                   pop_neg;

   // Accept and classify
   b2da_front #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_value    (req_value),
      .queue_status (queue_status),
      .push         (push),
      .push_mag     (push_mag),
      .push_neg     (push_neg)
   );

   // Decouple front and back
   b2da_queue #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .push_mag     (push_mag),
      .push_neg     (push_neg),
      .pop          (pop),
      .pop_mag      (pop_mag),
      .pop_neg      (pop_neg),
      .queue_status (queue_status)
   );

   // Convert and emit
   b2da_back #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .queue_status   (queue_status),
      .pop_mag        (pop_mag),
      .pop_neg        (pop_neg),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_text_char  (rsp_text_char),
      .rsp_char_count (rsp_char_count),
      .rsp_last       (rsp_last)
   );

endmodule

[rtl/core/b2da_checker.sv]
// ---------------------------------------------------------------------------
// Binary to decimal ASCII checker
// Port-level assertions on the response stream, bound to the core.
// ---------------------------------------------------------------------------
`include "binary_to_decimal_ascii_core_defines.svh"

module b2da_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            rsp_valid,
   input  logic                            rsp_stall,
   input  logic [b2da_pkg::CHAR_W-1:0]     rsp_text_char,
   input  logic [b2da_pkg::COUNT_W-1:0]    rsp_char_count,
   input  logic                            rsp_last
);
   import b2da_pkg::*;

   // Hold a stalled response
   `B2DA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_text_char) && $stable(rsp_char_count) && $stable(rsp_last), "stalled response changed")

   // Length only on the final character
   `B2DA_ASSERT_IMPLY(a_count_zero, clock, reset, rsp_valid && !rsp_last, rsp_char_count == '0, "length on a non-final character")

   // Length of a number stays within the text limit
   `B2DA_ASSERT_IMPLY(a_count_range, clock, reset, rsp_valid && rsp_last, (rsp_char_count != '0) && (rsp_char_count <= COUNT_W'(MAX_CHARS)), "length out of range")

   // A sign never ends a number and carries no length
   `B2DA_ASSERT_IMPLY(a_sign_first, clock, reset, rsp_valid && (rsp_text_char == CHAR_MINUS), !rsp_last && (rsp_char_count == '0), "sign character ends a number")

   // Only digits and the sign appear
   `B2DA_ASSERT_IMPLY(a_char_set, clock, reset, rsp_valid, (rsp_text_char == CHAR_MINUS) || ((rsp_text_char >= CHAR_ZERO) && (rsp_text_char <= CHAR_NINE)), "character outside the decimal set")

endmodule

bind binary_to_decimal_ascii_core b2da_checker u_b2da_checker (.*);

[test/b2da_text_checker.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Decimal text checker
// Watches the request, response and register ports of the conversion core,
// predicts the decimal characters of every accepted number and compares each
// response transfer, field by field, with the oldest predicted character.
// ---------------------------------------------------------------------------
module b2da_text_checker #(
   parameter int VALUE_WIDTH = b2da_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wr_en,
   input  logic                            csr_wr_data,
   input  logic                            req_valid,
   input  logic                            req_stall,
   input  logic [b2da_pkg::INPUT_W-1:0]    req_value,
   input  logic                            rsp_valid,
   input  logic                            rsp_stall,
   input  logic [b2da_pkg::CHAR_W-1:0]     rsp_text_char,
   input  logic [b2da_pkg::COUNT_W-1:0]    rsp_char_count,
   input  logic                            rsp_last,
   input  logic                            run_over,
   output int                              pending_count,
   output int                              fail_count
);
   import b2da_pkg::*;

   typedef struct packed {
      logic [CHAR_W-1:0]  text_char;
      logic [COUNT_W-1:0] char_count;
      logic               is_last;
   } text_char_type;

   localparam logic [INPUT_W-1:0] VALUE_MASK = {INPUT_W{1'b1}} >> (INPUT_W - VALUE_WIDTH);

   text_char_type expected_text[$];
   logic          signed_mode;
   int            mismatches = 0;
   bit            leftovers_checked = 1'b0;

   assign fail_count = mismatches;

   task automatic report_mismatch(input string what);
      $display("[%0t] mismatch: %s", $time, what);
      mismatches++;
   endtask

   // Append the characters of one number to the expected text
   function automatic void queue_decimal_text(input logic [INPUT_W-1:0] number,
                                              input logic as_signed);
      logic [INPUT_W-1:0] raw;
      logic [INPUT_W-1:0] magnitude;
      logic               negative;
      logic [DIGIT_W-1:0] digits[MAX_CHARS];
      int                 ndigits;
      int                 total;
      int                 first;
      text_char_type      entry;
      raw       = number & VALUE_MASK;
      negative  = as_signed && raw[VALUE_WIDTH-1];
      magnitude = negative ? ((~raw + 1'b1) & VALUE_MASK) : raw;
      ndigits   = 0;
      // collect digits, least significant first
      do begin
         digits[ndigits] = DIGIT_W'(magnitude % 64'd10);
         ndigits++;
         magnitude = magnitude / 64'd10;
      end while (magnitude != 0);
      total = ndigits + (negative ? 1 : 0);
      first = expected_text.size();
      if (negative) begin
         entry = '{text_char: CHAR_MINUS, char_count: '0, is_last: 1'b0};
         expected_text.push_back(entry);
      end
      for (int k = ndigits - 1; k >= 0; k--) begin
         entry = '{text_char: CHAR_ZERO + {4'd0, digits[k]}, char_count: '0, is_last: 1'b0};
         expected_text.push_back(entry);
      end
      // mark the final character with the length
      expected_text[first + total - 1].char_count = COUNT_W'(total);
      expected_text[first + total - 1].is_last    = 1'b1;
   endfunction

   always @(posedge clock) begin
      text_char_type want;
      if (reset) begin
         signed_mode = SIGNED_MODE_RESET;
         expected_text.delete();
      end else begin
         // predict each request transfer with the mode in force
         if (req_valid && !req_stall) begin
            queue_decimal_text(req_value, signed_mode);
         end
         if (csr_wr_en) begin
            signed_mode = csr_wr_data;
         end
         // compare each response transfer with the oldest prediction
         if (rsp_valid && !rsp_stall) begin
            if (expected_text.size() == 0) begin
               report_mismatch($sformatf("unexpected character 0x%02h", rsp_text_char));
            end else begin
               want = expected_text.pop_front();
               if (rsp_text_char !== want.text_char)
                  report_mismatch($sformatf("text_char 0x%02h, want 0x%02h",
                                            rsp_text_char, want.text_char));
               if (rsp_char_count !== want.char_count)
                  report_mismatch($sformatf("char_count %0d, want %0d",
                                            rsp_char_count, want.char_count));
               if (rsp_last !== want.is_last)
                  report_mismatch($sformatf("last %0b, want %0b", rsp_last, want.is_last));
            end
         end
         // flag characters that never arrived
         if (run_over && !leftovers_checked) begin
            leftovers_checked = 1'b1;
            if (expected_text.size() != 0)
               report_mismatch($sformatf("%0d characters never arrived",
                                         expected_text.size()));
         end
      end
      pending_count <= expected_text.size();
   end

endmodule

[test/tb.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Decimal text core testbench
// Feeds the conversion core with edge values in both modes, then phases of
// random numbers under varying register settings and random idling on both
// channels; the checker instance predicts and compares every character.
// ---------------------------------------------------------------------------
module tb;
   import b2da_pkg::*;

   localparam int CORE_WIDTH = VALUE_WIDTH_DEFAULT;
   localparam int PHASES     = 5;
   localparam int PHASE_LEN  = 18;

   localparam logic [INPUT_W-1:0] SIGNED_EDGES[12] = '{
      64'd0, 64'd1, 64'd9, 64'd10, 64'd99, 64'd100,
      64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFF6,
      64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
      64'h8000_0000_0000_0001, 64'd12345678901234567890
   };
   localparam logic [INPUT_W-1:0] UNSIGNED_EDGES[8] = '{
      64'd0, 64'd9, 64'd10, 64'hFFFF_FFFF_FFFF_FFFF,
      64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF,
      64'd10000000000000000000, 64'd9999999999999999999
   };

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_wr_en = 1'b0;
   logic                 csr_wr_data = 1'b0;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [INPUT_W-1:0]   req_value = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [CHAR_W-1:0]    rsp_text_char;
   logic [COUNT_W-1:0]   rsp_char_count;
   logic                 rsp_last;
   logic                 run_over = 1'b0;
   int                   pending_count;
   int                   fail_count;

   bit                   idling_on = 1'b1;
   logic                 mode_now = SIGNED_MODE_RESET;
   int                   n_signed = 0;
   int                   n_unsigned = 0;
   int                   n_settings = 0;

   always #5 clock = ~clock;

   binary_to_decimal_ascii_core #(
      .VALUE_WIDTH (CORE_WIDTH)
   ) u_top (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_text_char  (rsp_text_char),
      .rsp_char_count (rsp_char_count),
      .rsp_last       (rsp_last)
   );

   b2da_text_checker #(
      .VALUE_WIDTH (CORE_WIDTH)
   ) u_checker (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_text_char  (rsp_text_char),
      .rsp_char_count (rsp_char_count),
      .rsp_last       (rsp_last),
      .run_over       (run_over),
      .pending_count  (pending_count),
      .fail_count     (fail_count)
   );

   // Hold a request until it transfers, after an occasional idle burst
   task automatic send_number(input logic [INPUT_W-1:0] number);
      if (idling_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_value <= number;
      if (mode_now) n_signed++;
      else n_unsigned++;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Drop the request and wait until every character has come back
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   task automatic set_signed_mode(input logic mode);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= mode;
      mode_now = mode;
      n_settings++;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // Mix full-width, small, near powers of ten, short and small negative values
   function automatic logic [INPUT_W-1:0] random_number();
      logic [INPUT_W-1:0] power;
      int                 len;
      power = 64'd1;
      case ($urandom_range(0, 4))
         0: return {$urandom, $urandom};
         1: return INPUT_W'($urandom_range(0, 1000));
         2: begin
            repeat ($urandom_range(0, 19)) power = power * 64'd10;
            return power + INPUT_W'($urandom_range(0, 2)) - 64'd1;
         end
         3: begin
            len = $urandom_range(1, INPUT_W);
            return {$urandom, $urandom} >> (INPUT_W - len);
         end
         default: return 64'd0 - INPUT_W'($urandom_range(1, 100000));
      endcase
   endfunction

   // Stall responses in random bursts while idling is on
   initial begin
      forever begin
         @(posedge clock);
         if (idling_on && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 7)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      #2_000_000;
      $display("Timed out with %0d characters outstanding", pending_count);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      int guard;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // edge values under the reset mode, then unsigned
      foreach (SIGNED_EDGES[i]) send_number(SIGNED_EDGES[i]);
      wait_idle();
      set_signed_mode(1'b0);
      foreach (UNSIGNED_EDGES[i]) send_number(UNSIGNED_EDGES[i]);
      wait_idle();

      // random phases, alternating the mode; no idling in the last one
      for (int p = 0; p < PHASES; p++) begin
         set_signed_mode(p % 2 == 0);
         idling_on = (p < PHASES - 1);
         repeat (PHASE_LEN) send_number(random_number());
         wait_idle();
      end

      // let the core settle, then sweep for missing characters
      guard = 0;
      while (pending_count != 0 && guard < 5000) begin
         @(posedge clock);
         guard++;
      end
      repeat (30) @(posedge clock);
      run_over <= 1'b1;
      repeat (3) @(posedge clock);

      $display("Converted %0d numbers: %0d as two's complement, %0d as unsigned",
               n_signed + n_unsigned, n_signed, n_unsigned);
      $display("Mode register written %0d times, idling on both channels", n_settings);
      if (fail_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
